// File: hw/rtl/pcf_pkg.sv
// Shared types and constants of the PCM linear crossfade block.
// Field widths, divider sizing and output clamp limits; no dependencies.
`timescale 1ns / 1ps

package pcf_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int RLEN_W    = 16;
	localparam int CFG_W     = 7;
	localparam int S_TDATA_W = SAMPLE_W + RLEN_W;
	localparam int M_TDATA_W = SAMPLE_W;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd32;

	// The rounded quotient never exceeds 32768, so 18 quotient bits suffice.
	localparam int DIV_QW    = 18;
	localparam int DIV_STEPS = DIV_QW / 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	localparam logic [DIV_QW-1:0] Q_POS_LIM = 18'd32767;
	localparam logic [DIV_QW-1:0] Q_NEG_LIM = 18'd32768;

endpackage

// File: hw/rtl/pcf_tail_ram.sv
// Tail sample store: one write port and one registered read port.
// Uses pcf_pkg for the sample type.
`timescale 1ns / 1ps

module pcf_tail_ram
	import pcf_pkg::*;
#(
	parameter int AW    = 6,
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  sample_t       wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output sample_t       rdata
);

	sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold the read data until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/pcf_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Uses pcf_pkg for the quotient width and step count.
`timescale 1ns / 1ps

module pcf_div
	import pcf_pkg::*;
#(
	parameter int DW = 26,
	parameter int VW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     dividend,
	input  logic [VW-1:0]     divisor,
	output logic              done,
	output logic [DIV_QW-1:0] quotient
);

	localparam int CW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [VW-1:0]     rem_q;
	logic [VW-1:0]     div_q;
	logic [DIV_QW-1:0] quo_q;
	logic [VW:0]       step1;
	logic [VW:0]       step2;

	// One restoring step: returns {quotient bit, new remainder}.
	function automatic logic [VW:0] div_step(input logic [VW-1:0] r, input logic b,
			input logic [VW-1:0] d);
		logic [VW:0] t;
		logic [VW:0] dx;
		t  = {r, b};
		dx = {1'b0, d};
		if (t >= dx) begin
			t = t - dx;
			return {1'b1, t[VW-1:0]};
		end
		return {1'b0, t[VW-1:0]};
	endfunction

	assign step1 = div_step(rem_q, quo_q[DIV_QW-1], div_q);
	assign step2 = div_step(step1[VW-1:0], quo_q[DIV_QW-2], div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The upper dividend bits start below the divisor since the quotient fits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= VW'(dividend >> DIV_QW);
			quo_q <= dividend[DIV_QW-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= step2[VW-1:0];
			quo_q <= {quo_q[DIV_QW-3:0], step1[VW], step2[VW]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/pcm_linear_crossfade.sv
// Top level of the PCM linear crossfade: sequencer, blend datapath, output register.
// Uses pcf_pkg, pcf_tail_ram and pcf_div.
`timescale 1ns / 1ps

// Joins a left and a right chunk of signed 16-bit PCM with a linear crossfade.
// Left samples (s_tuser = 0) are delayed through a tail store that keeps the
// last min(overlap_length, MAX_OVERLAP) samples; older samples leave as results.
// The first right item (s_tuser = 1) carries the right length in s_tdata[31:16];
// the effective overlap n is the least of the cap, the held tail and that length,
// raised to one where the item would otherwise give over MAX_OVERLAP results.
// Surplus tail samples are emitted first, then right sample k < n is blended
// with the k-th remaining tail sample as (L*(n-k)+R*k)/n, rounded half away from
// zero and clamped; later right samples pass straight through. A right length
// of zero flushes the tail. m_tlast marks the final result of each input
// transfer; an input transfer can cause no result at all. One item is worked at
// a time and s_tready is high only while the sequencer is idle, also while a
// result still waits in the output register. A left sample is pushed, after a
// pop when the store is full, and then drains surplus; a blended right sample
// reads the tail, multiplies, sums and waits on the two-bit-per-cycle divider,
// and a pass-through one skips these steps. The tail store is one memory of
// 2**ceil(log2(MAX_OVERLAP)) samples with a registered read; the sequencer
// never reads and writes it in the same cycle, and it needs no clearing pass.
module pcm_linear_crossfade
	import pcf_pkg::*;
#(
	parameter int MAX_OVERLAP = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] in_sample, [31:16] right_length
	input  logic                 s_tuser,   // [0] op: 0 left sample, 1 right item
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] out_sample
	output logic                 m_tlast,   // run_last
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata  // overlap_length
);

	localparam int AW    = (MAX_OVERLAP > 1) ? $clog2(MAX_OVERLAP) : 1;
	localparam int DEPTH = 1 << AW;
	localparam int NW    = $clog2(MAX_OVERLAP + 1);
	localparam int PW    = SAMPLE_W + NW + 1;
	localparam int NUMW  = SAMPLE_W + NW + 2;
	localparam int DW    = NUMW + 1;
	localparam int VW    = NW + 1;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_POP_RD   = 4'd1;
	localparam logic [3:0] S_POP_OUT  = 4'd2;
	localparam logic [3:0] S_PUSH     = 4'd3;
	localparam logic [3:0] S_RIGHT    = 4'd4;
	localparam logic [3:0] S_MUL      = 4'd5;
	localparam logic [3:0] S_SUM      = 4'd6;
	localparam logic [3:0] S_DIVGO    = 4'd7;
	localparam logic [3:0] S_DIV      = 4'd8;
	localparam logic [3:0] S_BL_OUT   = 4'd9;
	localparam logic [3:0] S_PASS_OUT = 4'd10;

	// What the current run of tail pops belongs to.
	localparam logic [1:0] M_PRE     = 2'd0;  // pop before a push into a full store
	localparam logic [1:0] M_DRAIN   = 2'd1;  // pops after a push
	localparam logic [1:0] M_FLUSH   = 2'd2;  // empty right chunk
	localparam logic [1:0] M_SURPLUS = 2'd3;  // surplus ahead of the blend

	localparam logic [NW-1:0]     MAX_N  = NW'(MAX_OVERLAP);
	localparam logic [RLEN_W-1:0] RIDX_SAT = {RLEN_W{1'b1}};

	// Control state
	logic [3:0]        state_q, state_d;
	logic [1:0]        mode_q, mode_d;
	logic [CFG_W-1:0]  ovl_q;
	logic [NW-1:0]     fill_q, fill_d;
	logic [AW-1:0]     head_q, head_d;
	logic [NW-1:0]     eff_q, eff_d;
	logic [RLEN_W-1:0] ridx_q, ridx_d;
	logic              phase_q, phase_d;
	logic [NW-1:0]     cnt_q, cnt_d;
	logic [NW-1:0]     k_q, k_d;
	logic              m_tvalid_q;
	logic              m_tlast_q;

	// Payload
	sample_t               samp_q;
	sample_t               m_data_q;
	logic signed [PW-1:0]  prod_a_s2;
	logic signed [PW-1:0]  prod_b_s2;
	logic signed [NUMW-1:0] num_s3;

	// Memory and divider hookup
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	sample_t       ram_rdata;
	logic          div_start, div_done;
	logic [DW-1:0] div_dividend;
	logic [VW-1:0] div_divisor;
	logic [DIV_QW-1:0] div_quo;

	// Output staging
	logic    out_load;
	sample_t out_data;
	logic    out_last;
	logic    out_free;

	// Decode helpers
	logic              in_xfer;
	sample_t           in_sample;
	logic [RLEN_W-1:0] in_rlen;
	logic [NW-1:0]     cap;
	logic [NW-1:0]     eff_a, eff_b, eff_c;
	logic [NW:0]       surplus;
	logic [NW:0]       fill_p1;
	logic              drain_more;
	logic              num_neg;
	logic [NUMW-1:0]   num_u;
	logic [DW-1:0]     div_opa, div_opb;
	sample_t           blend_val;
	logic signed [NW:0] w_nk, w_k;

	assign in_xfer   = s_tvalid && s_tready;
	assign in_sample = sample_t'(s_tdata[SAMPLE_W-1:0]);
	assign in_rlen   = s_tdata[S_TDATA_W-1:SAMPLE_W];
	assign s_tready  = (state_q == S_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;

	// Cap the requested overlap at the store bound.
	assign cap = (ovl_q < CFG_W'(MAX_OVERLAP)) ? NW'(ovl_q) : MAX_N;

	// Effective overlap for the first right item.
	assign eff_a   = (fill_q < cap) ? fill_q : cap;
	assign eff_b   = (in_rlen < RLEN_W'(eff_a)) ? NW'(in_rlen) : eff_a;
	assign surplus = (NW+1)'(fill_q) - (NW+1)'(eff_b) + (NW+1)'(1);
	assign eff_c   = (surplus > (NW+1)'(MAX_OVERLAP))
		? NW'((NW+1)'(fill_q) + (NW+1)'(1) - (NW+1)'(MAX_OVERLAP)) : eff_b;

	// Drain test after a push: store one deeper than now.
	assign fill_p1    = (NW+1)'(fill_q) + (NW+1)'(1);
	assign drain_more = (fill_p1 > (NW+1)'(cap)) && (cnt_q < MAX_N);

	// Divider operands: 2*|num| + n, with |num| = ~num + 1 when negative.
	assign num_neg      = num_s3[NUMW-1];
	assign num_u        = num_s3;
	assign div_opa      = num_neg ? {~num_u, 1'b0} : {num_u, 1'b0};
	assign div_opb      = num_neg ? DW'(eff_q) + DW'(2) : DW'(eff_q);
	assign div_dividend = div_opa + div_opb;
	assign div_divisor  = {eff_q, 1'b0};

	// Restore the sign and clamp.
	always_comb begin
		logic [DIV_QW-1:0] neg_q;
		neg_q = '0 - div_quo;
		if (num_neg) begin
			blend_val = (div_quo > Q_NEG_LIM) ? SAMPLE_MIN : sample_t'(neg_q[SAMPLE_W-1:0]);
		end else begin
			blend_val = (div_quo > Q_POS_LIM) ? SAMPLE_MAX : sample_t'(div_quo[SAMPLE_W-1:0]);
		end
	end

	assign w_nk = {1'b0, eff_q - k_q};
	assign w_k  = {1'b0, k_q};

	// Sequencer
	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		fill_d    = fill_q;
		head_d    = head_q;
		eff_d     = eff_q;
		ridx_d    = ridx_q;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		k_d       = k_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = head_q + AW'(fill_q);
		ram_raddr = head_q;
		out_load  = 1'b0;
		out_data  = ram_rdata;
		out_last  = 1'b0;
		div_start = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					cnt_d = '0;
					if (!s_tuser) begin
						if (phase_q) begin
							// New left chunk: drop whatever tail was not blended.
							phase_d = 1'b0;
							fill_d  = '0;
							head_d  = '0;
							eff_d   = '0;
							ridx_d  = '0;
							state_d = S_PUSH;
						end else if (fill_q >= MAX_N) begin
							mode_d  = M_PRE;
							state_d = S_POP_RD;
						end else begin
							state_d = S_PUSH;
						end
					end else if (phase_q) begin
						state_d = S_RIGHT;
					end else if (in_rlen == '0) begin
						// Empty right chunk: flush the tail, stay in the left phase.
						if (fill_q != '0) begin
							mode_d  = M_FLUSH;
							state_d = S_POP_RD;
						end
					end else begin
						phase_d = 1'b1;
						eff_d   = eff_c;
						ridx_d  = '0;
						if (fill_q > eff_c) begin
							mode_d  = M_SURPLUS;
							state_d = S_POP_RD;
						end else begin
							state_d = S_RIGHT;
						end
					end
				end
			end
			S_POP_RD: begin
				ram_re  = 1'b1;
				head_d  = head_q + 1'b1;
				fill_d  = fill_q - 1'b1;
				cnt_d   = cnt_q + 1'b1;
				state_d = S_POP_OUT;
			end
			S_POP_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					case (mode_q)
						M_PRE: begin
							out_last = !drain_more;
							state_d  = S_PUSH;
						end
						M_DRAIN: begin
							out_last = !((fill_q > cap) && (cnt_q < MAX_N));
							state_d  = out_last ? S_IDLE : S_POP_RD;
						end
						M_FLUSH: begin
							out_last = (fill_q == '0);
							state_d  = out_last ? S_IDLE : S_POP_RD;
						end
						default: begin
							out_last = 1'b0;
							state_d  = (fill_q > eff_q) ? S_POP_RD : S_RIGHT;
						end
					endcase
				end
			end
			S_PUSH: begin
				ram_we = 1'b1;
				fill_d = fill_q + 1'b1;
				if (drain_more) begin
					mode_d  = M_DRAIN;
					state_d = S_POP_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RIGHT: begin
				if (ridx_q != RIDX_SAT) begin
					ridx_d = ridx_q + 1'b1;
				end
				if ((ridx_q < RLEN_W'(eff_q)) && (fill_q != '0)) begin
					ram_re  = 1'b1;
					head_d  = head_q + 1'b1;
					fill_d  = fill_q - 1'b1;
					k_d     = NW'(ridx_q);
					state_d = S_MUL;
				end else begin
					state_d = S_PASS_OUT;
				end
			end
			S_MUL: begin
				state_d = S_SUM;
			end
			S_SUM: begin
				state_d = S_DIVGO;
			end
			S_DIVGO: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_BL_OUT;
				end
			end
			S_BL_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_data = blend_val;
					out_last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_PASS_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_data = samp_q;
					out_last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= M_PRE;
			ovl_q      <= CFG_RESET;
			fill_q     <= '0;
			head_q     <= '0;
			eff_q      <= '0;
			ridx_q     <= '0;
			phase_q    <= 1'b0;
			cnt_q      <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			fill_q  <= fill_d;
			head_q  <= head_d;
			eff_q   <= eff_d;
			ridx_q  <= ridx_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
			if (cfg_we) begin
				ovl_q <= cfg_wdata;
			end
			// Hold the result until the transfer completes.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tlast_q  <= out_last;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			samp_q <= in_sample;
		end
		if (out_load) begin
			m_data_q <= out_data;
		end
		if (state_q == S_MUL) begin
			prod_a_s2 <= PW'(ram_rdata) * PW'(w_nk);
			prod_b_s2 <= PW'(samp_q) * PW'(w_k);
		end
		if (state_q == S_SUM) begin
			num_s3 <= NUMW'(prod_a_s2) + NUMW'(prod_b_s2);
		end
	end

	pcf_tail_ram #(
		.AW   (AW),
		.DEPTH(DEPTH)
	) u_tail_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(samp_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pcf_div #(
		.DW(DW),
		.VW(VW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_tlast_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_N)
		else $error("tail fill above bound");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("output register overwritten before transfer");

	a_tail_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && phase_q && ridx_q < RLEN_W'(eff_q)) |->
		((RLEN_W+1)'(fill_q) + (RLEN_W+1)'(ridx_q) == (RLEN_W+1)'(eff_q)))
		else $error("tail fill out of step with blend index");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide wait");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of the PCM linear crossfade block.
// Needs pcf_pkg and the pcm_linear_crossfade RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
	import pcf_pkg::*;

	localparam int OVL_MAX    = 64;
	localparam int TAIL_DEPTH = 64;
	localparam int ITEM_GOAL  = 300;
	localparam int SETTLE_CYC = 40;
	localparam int DRAIN_CYC  = 40;
	localparam int DIR_ROWS   = 23;

	// op codes carried in s_tuser
	localparam bit OP_LEFT  = 1'b0;
	localparam bit OP_RIGHT = 1'b1;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One row of the directed table. pin marks a row whose single result is
	// typed in by hand; the predictor still tracks its state change.
	typedef struct packed {
		row_kind_t        kind;
		logic             op;
		sample_t          smp;
		logic [15:0]      rlen;
		logic [CFG_W-1:0] cfgv;
		logic             pin;
		sample_t          pin_smp;
	} row_t;

	typedef struct {
		sample_t smp;
		bit      last;
	} out_beat_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [15:0] in_sample, [31:16] right_length
	logic                 s_tuser;   // [0] op
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // [15:0] out_sample
	logic                 m_tlast;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;

	// Crossfade state as the block should hold it
	sample_t          tail_mem [TAIL_DEPTH];
	int unsigned      tail_cnt;
	int unsigned      tail_rd;
	int unsigned      blend_n;
	int unsigned      right_pos;
	bit               right_on;
	logic [CFG_W-1:0] overlap_q;

	out_beat_t step_beats [$];   // results of the item just accepted
	out_beat_t due_q [$];        // results still owed by the block
	out_beat_t want;

	bit quiet;                   // no idling on either side while set
	int err_cnt;
	int items_sent;
	int beats_seen;
	int cfg_writes;
	int stall_left;

	row_t dir_tab [DIR_ROWS];

	pcm_linear_crossfade #(
		.MAX_OVERLAP(OVL_MAX)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic int unsigned overlap_cap();
		return (overlap_q < OVL_MAX) ? int'(overlap_q) : OVL_MAX;
	endfunction

	function automatic sample_t tail_pop();
		sample_t v;
		v        = tail_mem[tail_rd];
		tail_rd  = (tail_rd + 1) % TAIL_DEPTH;
		tail_cnt = tail_cnt - 1;
		return v;
	endfunction

	// (L*(n-k) + R*k) / n, rounded half away from zero, clamped to 16 bits
	function automatic sample_t blend_pcm(sample_t l, sample_t r, int k, int n);
		int num;
		int mag;
		int q;
		int v;
		num = int'(l) * (n - k) + int'(r) * k;
		mag = (num < 0) ? -num : num;
		q   = (2 * mag + n) / (2 * n);
		v   = (num < 0) ? -q : q;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return sample_t'(v);
	endfunction

	// One right sample: blend against the oldest held tail sample while
	// inside the overlap, otherwise pass it straight through.
	function automatic void right_beat(sample_t r);
		sample_t v;
		if (right_pos < blend_n && tail_cnt > 0)
			v = blend_pcm(tail_pop(), r, int'(right_pos), int'(blend_n));
		else
			v = r;
		step_beats.push_back('{smp: v, last: 1'b0});
		if (right_pos < 65535)
			right_pos++;
	endfunction

	function automatic void crossfade_step(bit op, sample_t smp, logic [15:0] rlen);
		int unsigned lim;
		step_beats = {};
		if (op == OP_LEFT) begin
			lim = overlap_cap();
			// a left sample after a right chunk opens a new left chunk
			if (right_on) begin
				right_on  = 1'b0;
				tail_cnt  = 0;
				tail_rd   = 0;
				blend_n   = 0;
				right_pos = 0;
			end
			if (tail_cnt >= OVL_MAX)
				step_beats.push_back('{smp: tail_pop(), last: 1'b0});
			tail_mem[(tail_rd + tail_cnt) % TAIL_DEPTH] = smp;
			tail_cnt++;
			while (tail_cnt > lim && step_beats.size() < OVL_MAX)
				step_beats.push_back('{smp: tail_pop(), last: 1'b0});
		end else if (right_on) begin
			right_beat(smp);
		end else if (rlen == 16'd0) begin
			// empty right chunk: flush the whole tail, stay in left phase
			while (tail_cnt > 0)
				step_beats.push_back('{smp: tail_pop(), last: 1'b0});
		end else begin
			lim = overlap_cap();
			if (tail_cnt < lim)
				lim = tail_cnt;
			if (rlen < lim)
				lim = rlen;
			// keep the burst of this item within OVL_MAX results
			if (tail_cnt - lim + 1 > OVL_MAX)
				lim = tail_cnt + 1 - OVL_MAX;
			while (tail_cnt > lim)
				step_beats.push_back('{smp: tail_pop(), last: 1'b0});
			right_on  = 1'b1;
			blend_n   = lim;
			right_pos = 0;
			right_beat(smp);
		end
		if (step_beats.size() > 0)
			step_beats[step_beats.size() - 1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic sample_t pick_pcm();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return sample_t'($urandom_range(0, 65535));
		endcase
	endfunction

	// Offer one item, hold it until the transfer, then log what it owes.
	task automatic send_item(bit op, sample_t smp, logic [15:0] rlen, bit pin,
			sample_t pin_smp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {rlen, smp};
		do @(posedge clk); while (!s_tready);
		crossfade_step(op, smp, rlen);
		if (pin)
			due_q.push_back('{smp: pin_smp, last: 1'b1});
		else
			foreach (step_beats[i])
				due_q.push_back(step_beats[i]);
		items_sent++;
	endtask

	// Write the overlap register only once the block has gone quiet.
	task automatic write_overlap(logic [CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		overlap_q = v;
		cfg_writes++;
	endtask

	task automatic send_lefts(int n);
		repeat (n) send_item(OP_LEFT, pick_pcm(), 16'($urandom), 1'b0, '0);
	endtask

	task automatic send_rights(int n);
		repeat (n) send_item(OP_RIGHT, pick_pcm(), 16'($urandom), 1'b0, '0);
	endtask

	// ---------------------------------------------------------------
	// Output side: random back-pressure and the result checker
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			m_tready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			beats_seen++;
			if (due_q.size() == 0) begin
				$error("out_sample: expected nothing, got %0d", $signed(m_tdata));
				err_cnt++;
			end else begin
				want = due_q.pop_front();
				if (sample_t'(m_tdata) !== want.smp) begin
					$error("out_sample: expected %0d, got %0d", want.smp, $signed(m_tdata));
					err_cnt++;
				end
				if (m_tlast !== want.last) begin
					$error("run_last: expected %0b, got %0b", want.last, m_tlast);
					err_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin : stim
		int          lim;
		int          nleft;
		int          nright;
		int          nchunk;
		logic [15:0] rlen;

		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= OP_LEFT;
		m_tready   <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		quiet      = 1'b0;
		err_cnt    = 0;
		items_sent = 0;
		beats_seen = 0;
		cfg_writes = 0;
		stall_left = 0;
		overlap_q  = CFG_RESET;
		tail_cnt   = 0;
		tail_rd    = 0;
		blend_n    = 0;
		right_pos  = 0;
		right_on   = 1'b0;

		// kind, op, in_sample, right_length, overlap, pinned, pinned result
		dir_tab = '{
			// empty right chunk with nothing held: no result
			'{ROW_ITEM, OP_RIGHT, 16'sd1234,   16'd0,     7'd0,   1'b0, 16'sd0},
			'{ROW_CFG,  OP_LEFT,  16'sd0,      16'd0,     7'd4,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_LEFT,  16'sd100,    16'd0,     7'd0,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_LEFT,  16'sd200,    16'd0,     7'd0,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_LEFT,  16'sd300,    16'd0,     7'd0,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_LEFT,  16'sd400,    16'd0,     7'd0,   1'b0, 16'sd0},
			// fifth sample pushes the oldest out of a 4-deep tail
			'{ROW_ITEM, OP_LEFT,  SAMPLE_MAX,  16'd0,     7'd0,   1'b1, 16'sd100},
			// right chunk shorter than the tail: surplus then blend
			'{ROW_ITEM, OP_RIGHT, SAMPLE_MIN,  16'd2,     7'd0,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_RIGHT, 16'sd0,      16'd0,     7'd0,   1'b0, 16'sd0},
			// past the declared length: pass through
			'{ROW_ITEM, OP_RIGHT, 16'sd5,      16'hFFFF,  7'd0,   1'b1, 16'sd5},
			'{ROW_ITEM, OP_LEFT,  -16'sd1,     16'd0,     7'd0,   1'b0, 16'sd0},
			// empty right chunk flushes the tail, in_sample ignored
			'{ROW_ITEM, OP_RIGHT, 16'sd777,    16'd0,     7'd0,   1'b1, -16'sd1},
			// zero overlap: everything passes straight through
			'{ROW_CFG,  OP_LEFT,  16'sd0,      16'd0,     7'd0,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_LEFT,  16'sd7,      16'd0,     7'd0,   1'b1, 16'sd7},
			'{ROW_ITEM, OP_RIGHT, 16'sd9,      16'hFFFF,  7'd0,   1'b1, 16'sd9},
			'{ROW_ITEM, OP_LEFT,  SAMPLE_MIN,  16'd0,     7'd0,   1'b1, SAMPLE_MIN},
			// overlap above the bound acts as the bound
			'{ROW_CFG,  OP_LEFT,  16'sd0,      16'd0,     7'd127, 1'b0, 16'sd0},
			'{ROW_ITEM, OP_LEFT,  SAMPLE_MAX,  16'hAAAA,  7'd0,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_LEFT,  SAMPLE_MIN,  16'h5555,  7'd0,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_LEFT,  16'sd1,      16'd0,     7'd0,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_RIGHT, SAMPLE_MAX,  16'd8,     7'd0,   1'b0, 16'sd0},
			// left sample mid-blend drops the unblended tail
			'{ROW_ITEM, OP_LEFT,  16'sd0,      16'd0,     7'd0,   1'b0, 16'sd0},
			'{ROW_ITEM, OP_RIGHT, 16'sd0,      16'd0,     7'd0,   1'b1, 16'sd0}
		};

		// hold reset, then release on a clock edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].kind == ROW_CFG)
				write_overlap(dir_tab[i].cfgv);
			else
				send_item(dir_tab[i].op, dir_tab[i].smp, dir_tab[i].rlen,
					dir_tab[i].pin, dir_tab[i].pin_smp);
		end

		// Full tail, then shrink the overlap: a left sample bursts OVL_MAX
		// results and leaves the rest to drain on later items.
		write_overlap(7'd64);
		send_lefts(OVL_MAX + $urandom_range(0, 4));
		write_overlap($urandom_range(0, 1));
		send_lefts(2);
		send_item(OP_RIGHT, pick_pcm(), 16'($urandom_range(1, 70)), 1'b0, '0);
		send_rights($urandom_range(0, 4));

		// Full tail, overlap dropped to zero, then a right chunk: the
		// effective overlap is raised to one to bound the burst.
		write_overlap(7'd64);
		send_lefts(OVL_MAX);
		write_overlap(7'd0);
		send_item(OP_RIGHT, pick_pcm(), 16'($urandom_range(1, 65535)), 1'b0, '0);
		send_rights($urandom_range(0, 3));

		// random phases: one overlap setting each, a few chunks per phase
		while (items_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 7))
				0: write_overlap(7'd0);
				1: write_overlap(7'd1);
				2: write_overlap(7'd64);
				3: write_overlap(7'd127);
				4: write_overlap($urandom_range(65, 126));
				default: write_overlap($urandom_range(2, 12));
			endcase
			quiet  = ($urandom_range(0, 4) == 0);
			nchunk = $urandom_range(1, 3);
			lim    = overlap_cap();
			repeat (nchunk) begin
				// stray empty right chunk now and then
				if ($urandom_range(0, 9) == 0)
					send_item(OP_RIGHT, pick_pcm(), 16'd0, 1'b0, '0);
				case ($urandom_range(0, 9))
					0: nleft = 0;
					1: nleft = $urandom_range(lim, 70);
					default: nleft = $urandom_range(0, lim + 3);
				endcase
				send_lefts(nleft);
				// sometimes leave the tail held into the next phase
				if ($urandom_range(0, 5) != 0) begin
					case ($urandom_range(0, 7))
						0: rlen = 16'd0;
						1: rlen = 16'($urandom);
						default: rlen = 16'($urandom_range(1, 70));
					endcase
					if (rlen == 16'd0)
						nright = 0;
					else begin
						nright = (int'(rlen) - 1 < lim + 2) ? int'(rlen) - 1 : lim + 2;
						case ($urandom_range(0, 5))
							0: nright = $urandom_range(0, 3);
							1: nright = nright + $urandom_range(1, 3);
							default: ;
						endcase
					end
					send_item(OP_RIGHT, pick_pcm(), rlen, 1'b0, '0);
					send_rights(nright);
				end
			end
		end

		// drop valid, wait out every owed result, then a short settle
		s_tvalid <= 1'b0;
		quiet = 1'b0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("tb_top: %0d input transfers, %0d result transfers checked",
			items_sent, beats_seen);
		$display("tb_top: %0d overlap writes, including 0, 1, 64 and 127", cfg_writes);
		if (err_cnt == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
